FILE: hw/rtl/iqdd_pkg.sv
// Shared types, constants and the coefficient generator for the IQ down-mix decimator.
package iqdd_pkg;

  // Default geometry
  localparam int unsigned SampleWidthDef   = 16;
  localparam int unsigned PhaseWidthDef    = 32;
  localparam int unsigned TableAddrBitsDef = 10;

  // Fixed register and coefficient widths
  localparam int unsigned PhaseStepWidth = 32;
  localparam int unsigned DecimWidth     = 9;
  localparam int unsigned CountWidth     = 8;
  localparam int unsigned ApbDataWidth   = 32;
  localparam int unsigned ApbAddrWidth   = 3;
  localparam int unsigned CoefWidth      = 17;
  localparam int unsigned CoefFrac       = 15;
  localparam int unsigned CordicSteps    = 20;
  localparam longint      CordicGain     = 64'sd652032874;

  // Largest decimation factor honoured
  localparam logic [DecimWidth-1:0] DecimMax = DecimWidth'(256);
  localparam logic [DecimWidth-1:0] DecimMin = DecimWidth'(1);

  // Arc tangent of 2^-i in units of 2^-32 turn
  localparam longint AtanTurns [CordicSteps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  // Register map, indexed by address bit 2
  typedef enum logic {
    RegPhaseStep   = 1'b0,
    RegDecimFactor = 1'b1
  } reg_idx_e;

  // Configuration handed to the phase and decimation stage
  typedef struct packed {
    logic [PhaseStepWidth-1:0] phase_step;
    logic [DecimWidth-1:0]     decim_factor;
  } cfg_t;

  // Control that travels with a sample into the mixer
  typedef struct packed {
    logic       valid;
    logic       first;
    logic [1:0] quad;
  } ctrl_t;

  // Round half up to scale 2^15 and clamp to [-32768, 32768]
  function automatic longint clamp_coef(longint v);
    longint r;
    r = (v + 64'sd16384) >>> CoefFrac;
    if (r > 64'sd32768) begin
      r = 64'sd32768;
    end
    if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r;
  endfunction

  // First-quadrant cosine and sine for one table entry, packed as {cos, sin}
  function automatic logic [2*CoefWidth-1:0] cordic_coef(int unsigned idx,
                                                         int unsigned addr_bits);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cx;
    longint sy;
    x = CordicGain;
    y = 64'sd0;
    z = longint'(idx) <<< (32 - addr_bits);
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - AtanTurns[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + AtanTurns[i];
      end
    end
    cx = clamp_coef(x);
    sy = clamp_coef(y);
    return {cx[CoefWidth-1:0], sy[CoefWidth-1:0]};
  endfunction

endpackage

FILE: hw/rtl/iqdd_regs.sv
// APB register block holding the phase step and the decimation factor.
module iqdd_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [iqdd_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [iqdd_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [iqdd_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready,
  output iqdd_pkg::cfg_t                      cfg_o
);

  logic                                  wr_en;
  iqdd_pkg::reg_idx_e                    reg_idx;
  logic [iqdd_pkg::PhaseStepWidth-1:0]   phase_step_q;
  logic [iqdd_pkg::DecimWidth-1:0]       decim_factor_q;

  // Decode the access
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = iqdd_pkg::reg_idx_e'(paddr[2]);

  // Hold the registers, update on the access phase of a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= '0;
      decim_factor_q <= iqdd_pkg::DecimMin;
    end else if (wr_en) begin
      case (reg_idx)
        iqdd_pkg::RegPhaseStep: begin
          phase_step_q <= pwdata[iqdd_pkg::PhaseStepWidth-1:0];
        end
        iqdd_pkg::RegDecimFactor: begin
          decim_factor_q <= pwdata[iqdd_pkg::DecimWidth-1:0];
        end
        default: begin
          phase_step_q <= phase_step_q;
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      iqdd_pkg::RegPhaseStep: begin
        prdata = phase_step_q;
      end
      iqdd_pkg::RegDecimFactor: begin
        prdata = {{(iqdd_pkg::ApbDataWidth-iqdd_pkg::DecimWidth){1'b0}}, decim_factor_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign cfg_o.phase_step   = phase_step_q;
  assign cfg_o.decim_factor = decim_factor_q;

endmodule

FILE: hw/rtl/iqdd_nco.sv
// Phase accumulator, decimation counter and quarter-wave coefficient ROM stage.
module iqdd_nco #(
  parameter int unsigned SampleWidth   = iqdd_pkg::SampleWidthDef,
  parameter int unsigned PhaseWidth    = iqdd_pkg::PhaseWidthDef,
  parameter int unsigned TableAddrBits = iqdd_pkg::TableAddrBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iqdd_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SampleWidth-1:0]        in_i_i,
  input  logic signed [SampleWidth-1:0]        in_q_i,
  input  logic                                 line_start_i,
  input  logic                                 advance_i,
  output iqdd_pkg::ctrl_t                      ctrl_o,
  output logic signed [SampleWidth-1:0]        smp_i_o,
  output logic signed [SampleWidth-1:0]        smp_q_o,
  output logic signed [iqdd_pkg::CoefWidth-1:0] rom_cos_o,
  output logic signed [iqdd_pkg::CoefWidth-1:0] rom_sin_o
);

  localparam int unsigned RomAddrBits = TableAddrBits - 2;
  localparam int unsigned RomDepth    = 2 ** RomAddrBits;
  localparam int unsigned EntryWidth  = 2 * iqdd_pkg::CoefWidth;

  logic [EntryWidth-1:0]             rom_w [RomDepth];
  logic [EntryWidth-1:0]             rom_q;

  logic [PhaseWidth-1:0]             phase_acc_q;
  logic [PhaseWidth-1:0]             phase_acc_d;
  logic [iqdd_pkg::CountWidth-1:0]   decim_count_q;
  logic [iqdd_pkg::CountWidth-1:0]   decim_count_d;

  logic                              accept;
  logic                              keep;
  logic [PhaseWidth-1:0]             phase_cur;
  logic [iqdd_pkg::CountWidth-1:0]   count_cur;
  logic [iqdd_pkg::CountWidth:0]     count_inc;
  logic [iqdd_pkg::DecimWidth-1:0]   decim_eff;
  logic [TableAddrBits-1:0]          tab_addr;
  logic [RomAddrBits-1:0]            rom_addr;

  iqdd_pkg::ctrl_t                   ctrl_q;
  logic signed [SampleWidth-1:0]     smp_i_q;
  logic signed [SampleWidth-1:0]     smp_q_q;

  // Build the quarter-wave table at elaboration
  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    localparam logic [EntryWidth-1:0] Entry = iqdd_pkg::cordic_coef(k, TableAddrBits);
    assign rom_w[k] = Entry;
  end

  // Take a new sample whenever the stage is empty or draining
  assign in_ready_o = !ctrl_q.valid || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // Restart phase and count on a line start
  assign phase_cur = line_start_i ? '0 : phase_acc_q;
  assign count_cur = line_start_i ? '0 : decim_count_q;
  assign keep      = (count_cur == '0);

  // Clamp the decimation factor into one to 256
  always_comb begin
    if (cfg_i.decim_factor == '0) begin
      decim_eff = iqdd_pkg::DecimMin;
    end else if (cfg_i.decim_factor > iqdd_pkg::DecimMax) begin
      decim_eff = iqdd_pkg::DecimMax;
    end else begin
      decim_eff = cfg_i.decim_factor;
    end
  end

  // Advance phase and count
  assign count_inc     = {1'b0, count_cur} + (iqdd_pkg::CountWidth+1)'(1);
  assign decim_count_d = (count_inc >= decim_eff) ? '0 : count_inc[iqdd_pkg::CountWidth-1:0];
  assign phase_acc_d   = phase_cur + cfg_i.phase_step[PhaseWidth-1:0];

  // Split the table address into quadrant and quarter-wave index
  assign tab_addr = phase_cur[PhaseWidth-1 -: TableAddrBits];
  assign rom_addr = tab_addr[RomAddrBits-1:0];

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q   <= '0;
      decim_count_q <= '0;
    end else if (accept) begin
      phase_acc_q   <= phase_acc_d;
      decim_count_q <= decim_count_d;
    end
  end

  // Stage register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (in_ready_o) begin
      ctrl_q.valid <= accept && keep;
      ctrl_q.first <= line_start_i;
      ctrl_q.quad  <= tab_addr[TableAddrBits-1 -: 2];
    end
  end

  // Stage register: sample and coefficient read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_i_q <= in_i_i;
      smp_q_q <= in_q_i;
      rom_q   <= rom_w[rom_addr];
    end
  end

  assign ctrl_o    = ctrl_q;
  assign smp_i_o   = smp_i_q;
  assign smp_q_o   = smp_q_q;
  assign rom_cos_o = rom_q[EntryWidth-1 -: iqdd_pkg::CoefWidth];
  assign rom_sin_o = rom_q[iqdd_pkg::CoefWidth-1:0];

endmodule

FILE: hw/rtl/iqdd_mixer.sv
// Quadrant fold, complex rotation, rounding and saturation into the output register.
module iqdd_mixer #(
  parameter int unsigned SampleWidth = iqdd_pkg::SampleWidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  iqdd_pkg::ctrl_t                        ctrl_i,
  input  logic signed [SampleWidth-1:0]          smp_i_i,
  input  logic signed [SampleWidth-1:0]          smp_q_i,
  input  logic signed [iqdd_pkg::CoefWidth-1:0]  rom_cos_i,
  input  logic signed [iqdd_pkg::CoefWidth-1:0]  rom_sin_i,
  output logic                                   advance_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [SampleWidth-1:0]          out_i_o,
  output logic signed [SampleWidth-1:0]          out_q_o,
  output logic                                   first_of_line_o
);

  localparam int unsigned ProdW = SampleWidth + iqdd_pkg::CoefWidth;
  localparam int unsigned SumW  = ProdW + 1;
  localparam logic signed [SumW-1:0] RoundHalf = SumW'(1) <<< (iqdd_pkg::CoefFrac - 1);
  localparam logic signed [SumW-1:0] SatHi     = (SumW'(1) <<< (SampleWidth - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] SatLo     = -SatHi - SumW'(1);

  logic signed [iqdd_pkg::CoefWidth-1:0] coef_c;
  logic signed [iqdd_pkg::CoefWidth-1:0] coef_s;
  logic signed [ProdW-1:0]               p_ic;
  logic signed [ProdW-1:0]               p_qs;
  logic signed [ProdW-1:0]               p_qc;
  logic signed [ProdW-1:0]               p_is;
  logic signed [SumW-1:0]                sum_i;
  logic signed [SumW-1:0]                sum_q;
  logic signed [SumW-1:0]                shr_i;
  logic signed [SumW-1:0]                shr_q;
  logic signed [SampleWidth-1:0]         sat_i;
  logic signed [SampleWidth-1:0]         sat_q;

  logic                                  out_valid_q;
  logic signed [SampleWidth-1:0]         out_i_q;
  logic signed [SampleWidth-1:0]         out_q_q;
  logic                                  first_q;

  // Fold the first-quadrant pair into the full turn
  always_comb begin
    case (ctrl_i.quad)
      2'd0: begin
        coef_c = rom_cos_i;
        coef_s = rom_sin_i;
      end
      2'd1: begin
        coef_c = -rom_sin_i;
        coef_s = rom_cos_i;
      end
      2'd2: begin
        coef_c = -rom_cos_i;
        coef_s = -rom_sin_i;
      end
      default: begin
        coef_c = rom_sin_i;
        coef_s = -rom_cos_i;
      end
    endcase
  end

  // Rotate by the conjugate phasor
  assign p_ic  = ProdW'(smp_i_i) * ProdW'(coef_c);
  assign p_qs  = ProdW'(smp_q_i) * ProdW'(coef_s);
  assign p_qc  = ProdW'(smp_q_i) * ProdW'(coef_c);
  assign p_is  = ProdW'(smp_i_i) * ProdW'(coef_s);
  assign sum_i = SumW'(p_ic) + SumW'(p_qs) + RoundHalf;
  assign sum_q = SumW'(p_qc) - SumW'(p_is) + RoundHalf;
  assign shr_i = sum_i >>> iqdd_pkg::CoefFrac;
  assign shr_q = sum_q >>> iqdd_pkg::CoefFrac;

  // Saturate to the sample range
  always_comb begin
    if (shr_i > SatHi) begin
      sat_i = SatHi[SampleWidth-1:0];
    end else if (shr_i < SatLo) begin
      sat_i = SatLo[SampleWidth-1:0];
    end else begin
      sat_i = shr_i[SampleWidth-1:0];
    end
    if (shr_q > SatHi) begin
      sat_q = SatHi[SampleWidth-1:0];
    end else if (shr_q < SatLo) begin
      sat_q = SatLo[SampleWidth-1:0];
    end else begin
      sat_q = shr_q[SampleWidth-1:0];
    end
  end

  // Move on when the output register is free or being drained
  assign advance_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= ctrl_i.valid;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (advance_o && ctrl_i.valid) begin
      out_i_q <= sat_i;
      out_q_q <= sat_q;
      first_q <= ctrl_i.first;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_i_o         = out_i_q;
  assign out_q_o         = out_q_q;
  assign first_of_line_o = first_q;

endmodule

FILE: hw/rtl/iq_downmix_decimator_unit.sv
// Top level of the IQ down-mix decimator: register port, phase stage and mixer.
//
// Takes one complex sample per clock, unless the output stalls, and rotates it by
// exp(-j*theta), theta being the phase accumulator, then keeps one sample in every
// decimation_factor (starting at the sample index zero of each line, marked by
// line_start). A kept sample passes the stage register, which holds the sample and
// the coefficient ROM read, and then the output register, which takes the multiply,
// round and saturate. The coefficient ROM holds a quarter wave of
// 2^(TABLE_ADDR_BITS-2) entries, generated at elaboration, so there is no start-up pass.
// Register 0 (byte address 0) is the phase step in 2^-PHASE_WIDTH of a turn; register 1
// (byte address 4) is the decimation factor, where 0 acts as 1 and values above 256 as 256.
// Write registers only while no sample is in flight.
module iq_downmix_decimator_unit #(
  parameter int unsigned SAMPLE_WIDTH    = iqdd_pkg::SampleWidthDef,
  parameter int unsigned PHASE_WIDTH     = iqdd_pkg::PhaseWidthDef,
  parameter int unsigned TABLE_ADDR_BITS = iqdd_pkg::TableAddrBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [iqdd_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [iqdd_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [iqdd_pkg::ApbDataWidth-1:0]  prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_q_i,
  input  logic                               line_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]     out_i_o,
  output logic signed [SAMPLE_WIDTH-1:0]     out_q_o,
  output logic                               first_of_line_o
);

  iqdd_pkg::cfg_t                        cfg;
  iqdd_pkg::ctrl_t                       ctrl;
  logic                                  advance;
  logic signed [SAMPLE_WIDTH-1:0]        smp_i;
  logic signed [SAMPLE_WIDTH-1:0]        smp_q;
  logic signed [iqdd_pkg::CoefWidth-1:0] rom_cos;
  logic signed [iqdd_pkg::CoefWidth-1:0] rom_sin;

  iqdd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iqdd_nco #(
    .SampleWidth   (SAMPLE_WIDTH),
    .PhaseWidth    (PHASE_WIDTH),
    .TableAddrBits (TABLE_ADDR_BITS)
  ) u_nco (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i_i       (in_i_i),
    .in_q_i       (in_q_i),
    .line_start_i (line_start_i),
    .advance_i    (advance),
    .ctrl_o       (ctrl),
    .smp_i_o      (smp_i),
    .smp_q_o      (smp_q),
    .rom_cos_o    (rom_cos),
    .rom_sin_o    (rom_sin)
  );

  iqdd_mixer #(
    .SampleWidth (SAMPLE_WIDTH)
  ) u_mixer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .smp_i_i         (smp_i),
    .smp_q_i         (smp_q),
    .rom_cos_i       (rom_cos),
    .rom_sin_i       (rom_sin),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_i_o         (out_i_o),
    .out_q_o         (out_q_o),
    .first_of_line_o (first_of_line_o)
  );

endmodule

FILE: tb/iq_downmix_decimator_checker.sv
// Checker for the IQ down-mix decimator: watches the channels, predicts the kept samples and compares.
`timescale 1ns / 1ps

module iq_downmix_decimator_checker
  import iqdd_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ApbAddrWidth-1:0]          paddr,
  input  logic [ApbDataWidth-1:0]          pwdata,
  input  logic                             pready,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic signed [SampleWidthDef-1:0] in_i_i,
  input  logic signed [SampleWidthDef-1:0] in_q_i,
  input  logic                             line_start_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic signed [SampleWidthDef-1:0] out_i_o,
  input  logic signed [SampleWidthDef-1:0] out_q_o,
  input  logic                             first_of_line_o,
  input  logic                             drain_check_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               samples_o,
  output int                               results_o
);

  localparam int unsigned SampleW   = SampleWidthDef;
  localparam int unsigned TableBits = TableAddrBitsDef;
  localparam int unsigned RotSteps  = 20;
  localparam int          MaxPeriod = 256;
  localparam longint      RotStartX = 64'sd652032874;
  localparam longint      SampleMax = (64'sd1 <<< (SampleW - 1)) - 1;
  localparam longint      SampleMin = -SampleMax - 1;

  // Rotation angles of 2^-k in units of 2^-32 turn
  localparam longint RotAngle [RotSteps] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
  };

  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
    logic                      first;
  } mixed_sample_t;

  // Register copies and mixer state
  logic [PhaseStepWidth-1:0] phase_step   = '0;
  logic [DecimWidth-1:0]     decim_factor = DecimWidth'(1);
  logic [PhaseStepWidth-1:0] phase_acc    = '0;
  logic [CountWidth-1:0]     decim_count  = '0;

  mixed_sample_t downmixed_q[$];
  int fails         = 0;
  int samples       = 0;
  int results       = 0;
  bit drain_checked = 1'b0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    samples_o    = 0;
    results_o    = 0;
  end

  // Round half up to scale 2^15 and clamp to one above full scale
  function automatic longint round_coef(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32768) r = 64'sd32768;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // Round half up and saturate a product sum to the sample range
  function automatic logic signed [SampleW-1:0] round_to_sample(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > SampleMax) r = SampleMax;
    if (r < SampleMin) r = SampleMin;
    return r[SampleW-1:0];
  endfunction

  // Cosine and sine of one table address: quadrant from the top bits, rest by rotation
  function automatic void table_cos_sin(input logic [TableBits-1:0] addr,
                                        output longint c_val, output longint s_val);
    logic [31:0] angle;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      cx;
    longint      sy;
    angle = {addr, {(32 - TableBits){1'b0}}};
    z     = longint'({2'b00, angle[29:0]});
    x     = RotStartX;
    y     = 64'sd0;
    for (int k = 0; k < RotSteps; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - RotAngle[k];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + RotAngle[k];
      end
    end
    cx = round_coef(x);
    sy = round_coef(y);
    case (angle[31:30])
      2'd0: begin
        c_val = cx;
        s_val = sy;
      end
      2'd1: begin
        c_val = -sy;
        s_val = cx;
      end
      2'd2: begin
        c_val = -cx;
        s_val = -sy;
      end
      default: begin
        c_val = sy;
        s_val = -cx;
      end
    endcase
  endfunction

  // Rotate one accepted sample, queue it if kept, and advance phase and count
  task automatic mix_and_decimate(input logic signed [SampleW-1:0] re,
                                  input logic signed [SampleW-1:0] im,
                                  input logic                      line_start);
    logic [PhaseStepWidth-1:0] phase;
    int                        count;
    int                        period;
    longint                    c_val;
    longint                    s_val;
    mixed_sample_t             kept;
    phase = line_start ? '0 : phase_acc;
    count = line_start ? 0 : int'(decim_count);
    if (decim_factor == '0) begin
      period = 1;
    end else if (int'(decim_factor) > MaxPeriod) begin
      period = MaxPeriod;
    end else begin
      period = int'(decim_factor);
    end
    if (count == 0) begin
      table_cos_sin(phase[PhaseStepWidth-1 -: TableBits], c_val, s_val);
      kept.re    = round_to_sample(longint'(re) * c_val + longint'(im) * s_val);
      kept.im    = round_to_sample(longint'(im) * c_val - longint'(re) * s_val);
      kept.first = line_start;
      downmixed_q.insert(downmixed_q.size(), kept);
    end
    phase_acc = phase + phase_step;
    count++;
    if (count >= period) count = 0;
    decim_count = CountWidth'(count);
  endtask

  // Track register writes, predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    mixed_sample_t want;
    if (!rst_ni) begin
      phase_step   = '0;
      decim_factor = DecimWidth'(1);
      phase_acc    = '0;
      decim_count  = '0;
      downmixed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          RegPhaseStep:   phase_step = pwdata[PhaseStepWidth-1:0];
          RegDecimFactor: decim_factor = pwdata[DecimWidth-1:0];
          default: ;
        endcase
      end

      if (out_valid_o && out_ready_i) begin
        results++;
        if (downmixed_q.size() == 0) begin
          $error("unexpected result: out_i %0d out_q %0d first_of_line %0b",
                 out_i_o, out_q_o, first_of_line_o);
          fails++;
        end else begin
          want = downmixed_q.pop_front();
          if (out_i_o !== want.re) begin
            $error("out_i: expected %0d, actual %0d", want.re, out_i_o);
            fails++;
          end
          if (out_q_o !== want.im) begin
            $error("out_q: expected %0d, actual %0d", want.im, out_q_o);
            fails++;
          end
          if (first_of_line_o !== want.first) begin
            $error("first_of_line: expected %0b, actual %0b", want.first, first_of_line_o);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_o) begin
        mix_and_decimate(in_i_i, in_q_i, line_start_i);
        samples++;
      end

      // Report anything still owed once the stimulus has drained
      if (drain_check_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (downmixed_q.size() != 0) begin
          $error("%0d expected results never arrived", downmixed_q.size());
          fails++;
        end
      end

      fail_count_o <= fails;
      pending_o    <= downmixed_q.size();
      samples_o    <= samples;
      results_o    <= results;
    end
  end

endmodule

FILE: tb/iq_downmix_decimator_unit_tb.sv
// Top of the IQ down-mix decimator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module iq_downmix_decimator_unit_tb;
  import iqdd_pkg::*;

  localparam int unsigned SampleW      = SampleWidthDef;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TimeoutNs    = 5_000_000;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [ApbAddrWidth-1:0]   paddr         = '0;
  logic [ApbDataWidth-1:0]   pwdata        = '0;
  logic [ApbDataWidth-1:0]   prdata;
  logic                      pready;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] in_i_i        = '0;
  logic signed [SampleW-1:0] in_q_i        = '0;
  logic                      line_start_i  = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic signed [SampleW-1:0] out_i_o;
  logic signed [SampleW-1:0] out_q_o;
  logic                      first_of_line_o;
  logic                      drain_check_i = 1'b0;
  int                        fail_count_o;
  int                        pending_o;
  int                        samples_o;
  int                        results_o;

  int send_idle_pct = 29;
  int recv_idle_pct = 51;
  int settings_used = 1;

  iq_downmix_decimator_unit dut (.*);

  iq_downmix_decimator_checker u_checker (.*);

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the output at the current rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard stop if the run hangs
  initial begin
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

  // Offer one sample, idling at random first, and hold it until the transaction
  task automatic push_sample(input logic [SampleW-1:0] re, input logic [SampleW-1:0] im,
                             input logic line_start);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_i_i       <= re;
    in_q_i       <= im;
    line_start_i <= line_start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid, wait for every kept sample, then let dropped ones leave the pipe
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_o != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup and access cycle of one register write
  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataWidth-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrWidth'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Full-scale and zero levels often, anything otherwise
  function automatic logic [SampleW-1:0] pick_level();
    case ($urandom_range(7))
      0:       return {1'b0, {(SampleW - 1){1'b1}}};
      1:       return {1'b1, {(SampleW - 1){1'b0}}};
      2:       return '0;
      default: return SampleW'($urandom);
    endcase
  endfunction

  initial begin
    int          line_left;
    int          max_line;
    int          noise_div;
    int          phase_items;
    bit          long_lines;
    logic        line_bit;
    logic [31:0] step_val;
    logic [8:0]  decim_val;

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, no line start yet
    push_sample(16'sh7FFF, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 16'sh7FFF, 1'b0);
    push_sample(16'sh0000, 16'sh0000, 1'b0);

    // Eighth-turn step through all quadrants, zero decimation acts as one
    wait_idle();
    apb_write(RegPhaseStep, 32'h2000_0000);
    apb_write(RegDecimFactor, 32'd0);
    settings_used++;
    push_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
    push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    push_sample(16'sh0001, 16'shFFFF, 1'b0);

    // Oversized decimation clamps to 256; a line restart after dropped samples
    wait_idle();
    apb_write(RegPhaseStep, 32'hFFFF_FFFF);
    apb_write(RegDecimFactor, 32'd300);
    settings_used++;
    push_sample(16'sh1234, 16'shEDCB, 1'b1);
    push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh4000, 16'shC000, 1'b0);
    push_sample(16'sh7FFF, 16'sh8000, 1'b1);

    // Quarter-turn step with decimation by three
    wait_idle();
    apb_write(RegPhaseStep, 32'h4000_0000);
    apb_write(RegDecimFactor, 32'd3);
    settings_used++;
    push_sample(16'sh5A5A, 16'shA5A5, 1'b1);
    for (int n = 0; n < 5; n++) begin
      push_sample(pick_level(), pick_level(), 1'b0);
    end

    // Random lines under several settings and stall patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          step_val  = $urandom;
          decim_val = 9'd1;
        end
        1: begin
          step_val  = 32'hFFFF_FFFF;
          decim_val = 9'd2;
        end
        2: begin
          step_val  = $urandom;
          decim_val = 9'($urandom_range(1, 8));
        end
        3: begin
          step_val  = 32'h0000_0000;
          decim_val = 9'd256;
        end
        4: begin
          step_val  = $urandom;
          decim_val = 9'd511;
        end
        5: begin
          step_val  = $urandom >> 8;
          decim_val = 9'd5;
        end
        default: begin
          step_val  = 32'h8000_0000;
          decim_val = 9'd1;
        end
      endcase

      if (ph < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 51;
      end else if (ph < 4) begin
        send_idle_pct = 51;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      wait_idle();
      apb_write(RegPhaseStep, step_val);
      apb_write(RegDecimFactor, 32'(decim_val));
      settings_used++;

      // Long lines reach past the decimation period when it is large
      long_lines  = (decim_val >= 9'd256);
      max_line    = long_lines ? 300 : 48;
      noise_div   = long_lines ? 0 : 25;
      phase_items = long_lines ? 300 : 180;
      line_left   = 0;

      for (int n = 0; n < phase_items; n++) begin
        if ((ph == 2 || ph == 5) && n == phase_items / 2) begin
          wait_idle();
        end
        if (noise_div != 0 && $urandom_range(noise_div - 1) == 0) begin
          line_bit = 1'($urandom_range(1));
        end else if (line_left == 0) begin
          line_bit  = 1'b1;
          line_left = long_lines ? $urandom_range(200, max_line) : $urandom_range(1, max_line);
        end else begin
          line_bit = 1'b0;
        end
        if (line_left > 0) line_left--;
        push_sample(pick_level(), pick_level(), line_bit);
      end
    end

    // Drain, then have the checker report anything left over
    wait_idle();
    @(negedge clk_i);
    drain_check_i <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);

    $display("Run summary: %0d samples sent under %0d register settings, %0d results compared",
             samples_o, settings_used, results_o);
    $display("Covered line restarts, dropped samples, clamped decimation and both stall orders");
    if (fail_count_o == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
